FILE: rtl/ordered_byte_list_engine_top_assert.svh
// Assertion macros for the ordered byte list engine checker.
`ifndef ORDERED_BYTE_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_BYTE_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OBL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obl check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define OBL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obl check failed");

`endif

FILE: rtl/obl_pkg.sv
// Shared types and constants for the ordered byte list engine.
package obl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = CNT_W + 8;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_GET    = 3'd3,
        ACT_LOCATE = 3'd4
    } action_t;

    typedef struct packed {
        logic             en;
        action_t          act;
        logic [IDX_W-1:0] idx;
        logic [7:0]       value;
    } cell_cmd_t;

endpackage

FILE: rtl/obl_cell.sv
// One storage cell of the list chain: holds a byte, shifts with its neighbors.
module obl_cell (
    input  logic                     clk,
    input  obl_pkg::cell_cmd_t       cmd,
    input  logic [obl_pkg::IDX_W-1:0] cell_idx,
    input  logic [7:0]               left,
    input  logic [7:0]               right,
    output logic [7:0]               slot,
    output logic                     match
);
    import obl_pkg::*;

    logic [7:0] slot_reg;
    logic [7:0] slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.en)
        begin
            case (cmd.act)
                ACT_APPEND:
                begin
                    if (cell_idx == cmd.idx)
                        slot_next = cmd.value;
                end
                ACT_INSERT:
                begin
                    if (cell_idx == cmd.idx)
                        slot_next = cmd.value;
                    else if (cell_idx > cmd.idx)
                        slot_next = left;
                end
                ACT_DELETE:
                begin
                    if (cell_idx >= cmd.idx)
                        slot_next = right;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot  = slot_reg;
    assign match = (slot_reg == cmd.value);

endmodule

FILE: rtl/ordered_byte_list_engine_top.sv
// Top level of the ordered byte list engine: command decode, cell chain, result register.
//
//  channel  | dir | payload
//  s_*      | in  | tuser: action; tdata: position, value
//  m_*      | out | tdata: ok, data_out, found_at, count, is_empty
//
// Each request is decoded and applied to the whole cell chain in the cycle it is accepted;
// its result is registered and shown the next cycle.
// Throughput is one transaction per cycle; the result register is the only stage.
// A stalled result blocks new requests until m_tready takes it.
// Reset empties the list (fill count to zero); no clearing pass is needed.
module ordered_byte_list_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // [2:0] action
    input  logic [15:0] s_tdata,   // [7:0] position, [15:8] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] ok, [8:1] data_out, [13:9] found_at,
                                   // [18:14] count, [19] is_empty, [23:20] zero
);
    import obl_pkg::*;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             out_valid_reg;
    logic [19:0]      out_data_reg;

    logic             accept;
    action_t          act;
    logic [7:0]       pos;
    logic [7:0]       val;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] fill_ext;
    logic             full;
    logic             rd_ok;
    logic             ins_ok;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] rd_idx;

    logic             ok;
    logic [7:0]       data;
    logic [CNT_W-1:0] found;
    cell_cmd_t        cmd;

    logic [7:0]       slot   [CAPACITY];
    logic             match  [CAPACITY];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign act      = action_t'(s_tuser);
    assign pos      = s_tdata[7:0];
    assign val      = s_tdata[15:8];
    assign pos_ext  = CMP_W'(pos);
    assign fill_ext = CMP_W'(fill_reg);
    assign full     = (fill_reg == CNT_W'(CAPACITY));
    assign rd_ok    = (pos != 8'd0) && (pos_ext <= fill_ext);
    assign ins_ok   = (pos != 8'd0) && (pos_ext <= fill_ext + CMP_W'(1)) && !full;
    assign pos_idx  = IDX_W'(pos_ext - CMP_W'(1));
    assign rd_idx   = rd_ok ? pos_idx : '0;

    // request decode and result
    always_comb
    begin
        ok        = 1'b0;
        data      = 8'd0;
        found     = '0;
        fill_next = fill_reg;
        cmd.en    = 1'b0;
        cmd.act   = act;
        cmd.idx   = pos_idx;
        cmd.value = val;
        case (act)
            ACT_APPEND:
            begin
                cmd.idx = IDX_W'(fill_reg);
                if (!full)
                begin
                    ok        = 1'b1;
                    cmd.en    = accept;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            ACT_INSERT:
            begin
                if (ins_ok)
                begin
                    ok        = 1'b1;
                    cmd.en    = accept;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            ACT_DELETE:
            begin
                if (rd_ok)
                begin
                    ok        = 1'b1;
                    data      = slot[rd_idx];
                    cmd.en    = accept;
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            ACT_GET:
            begin
                if (rd_ok)
                begin
                    ok   = 1'b1;
                    data = slot[rd_idx];
                end
            end
            ACT_LOCATE:
            begin
                // lowest matching cell wins
                for (int i = CAPACITY - 1; i >= 0; i--)
                begin
                    if (match[i] && (CNT_W'(i) < fill_reg))
                    begin
                        found = CNT_W'(i + 1);
                        ok    = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [7:0] left_in;
        logic [7:0] right_in;
        if (g == 0)
        begin : g_first
            assign left_in = 8'd0;
        end
        else
        begin : g_mid
            assign left_in = slot[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_in = slot[g];
        end
        else
        begin : g_inner
            assign right_in = slot[g+1];
        end
        obl_cell u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .cell_idx (IDX_W'(g)),
            .left     (left_in),
            .right    (right_in),
            .slot     (slot[g]),
            .match    (match[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {(fill_next == '0), 5'(fill_next), 5'(found), data, ok};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

endmodule

FILE: rtl/obl_checker.sv
// Port-level checker for the ordered byte list engine, bound to the top level.
`include "ordered_byte_list_engine_top_assert.svh"

module obl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import obl_pkg::*;

    `OBL_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `OBL_ASSERT_IMP(a_empty, m_tvalid, m_tdata[19] == (m_tdata[18:14] == 5'd0))
    `OBL_ASSERT_IMP(a_found_ok, m_tvalid && (m_tdata[13:9] != 5'd0), m_tdata[0])
    `OBL_ASSERT_IMP(a_count_cap, m_tvalid, 32'(m_tdata[18:14]) <= 32'(CAPACITY % 32))

endmodule

bind ordered_byte_list_engine_top obl_checker u_obl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/testbench.sv
// Self-checking testbench for the ordered byte list engine.
module testbench;

    import obl_pkg::*;

    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
    localparam int         LIMIT_CYCLES     = 200000;
    localparam int         MAX_PRINTS       = 40;

    // same bit order as m_tdata[19:0]
    typedef struct packed {
        logic             is_empty;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] found_at;
        logic [7:0]       data_out;
        logic             ok;
    } list_result_t;

    class obl_list_checker;
        logic [7:0]   slots [CAPACITY];
        int           fill;
        list_result_t pending_results [$];
        int           errors;
        int           n_requests;
        int           n_results;
        int           n_full_refusals;
        int           n_locate_hits;

        function new();
            fill            = 0;
            errors          = 0;
            n_requests      = 0;
            n_results       = 0;
            n_full_refusals = 0;
            n_locate_hits   = 0;
        endfunction

        function void note_request(logic [2:0] act, logic [7:0] pos, logic [7:0] val);
            list_result_t r;
            int           p;
            int           k;
            r = '0;
            p = pos;
            n_requests++;
            case (act)
                ACT_APPEND:
                begin
                    if (fill < CAPACITY)
                    begin
                        slots[fill] = val;
                        fill++;
                        r.ok = 1'b1;
                    end
                    else
                        n_full_refusals++;
                end
                ACT_INSERT:
                begin
                    if (fill == CAPACITY)
                        n_full_refusals++;
                    if (p >= 1 && p <= fill + 1 && fill < CAPACITY)
                    begin
                        for (k = fill; k > p - 1; k--)
                            slots[k] = slots[k - 1];
                        slots[p - 1] = val;
                        fill++;
                        r.ok = 1'b1;
                    end
                end
                ACT_DELETE:
                begin
                    if (p >= 1 && p <= fill)
                    begin
                        r.data_out = slots[p - 1];
                        for (k = p - 1; k + 1 < fill; k++)
                            slots[k] = slots[k + 1];
                        fill--;
                        r.ok = 1'b1;
                    end
                end
                ACT_GET:
                begin
                    if (p >= 1 && p <= fill)
                    begin
                        r.data_out = slots[p - 1];
                        r.ok       = 1'b1;
                    end
                end
                ACT_LOCATE:
                begin
                    for (k = 0; k < fill && !r.ok; k++)
                    begin
                        if (slots[k] == val)
                        begin
                            r.found_at = CNT_W'(k + 1);
                            r.ok       = 1'b1;
                        end
                    end
                    if (r.ok)
                        n_locate_hits++;
                end
                default:
                begin
                end
            endcase
            r.count    = CNT_W'(fill);
            r.is_empty = (fill == 0);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch on result %0d: %s got 0x%0h want 0x%0h",
                         n_results, what, got, want);
        endtask

        task check_result(logic [23:0] word);
            list_result_t got;
            list_result_t want;
            n_results++;
            got = word[19:0];
            if (word[23:20] != '0)
                report_mismatch("pad bits", word[23:20], 0);
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding", got, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.ok != want.ok)
                report_mismatch("ok", got.ok, want.ok);
            if (got.data_out != want.data_out)
                report_mismatch("data_out", got.data_out, want.data_out);
            if (got.found_at != want.found_at)
                report_mismatch("found_at", got.found_at, want.found_at);
            if (got.count != want.count)
                report_mismatch("count", got.count, want.count);
            if (got.is_empty != want.is_empty)
                report_mismatch("is_empty", got.is_empty, want.is_empty);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    obl_list_checker sb = new();

    int         burst_left   = 0;
    bit         gapless      = 1'b0;
    int         hold_request = 0;
    int         cycle_count  = 0;
    logic [7:0] value_pool [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

    ordered_byte_list_engine_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // valid low, with junk on the bus
    task automatic go_idle(input int n);
        s_tvalid <= 1'b0;
        s_tuser  <= 3'($urandom_range(0, 7));
        s_tdata  <= 16'($urandom);
        repeat (n) @(posedge clk);
    endtask

    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if (!gapless)
                go_idle($urandom_range(1, 6));
            gapless    = ($urandom_range(0, 4) == 0);
            burst_left = gapless ? $urandom_range(20, 60) : $urandom_range(0, 10);
        end
    endtask

    task automatic send_request(input logic [2:0] act, input logic [7:0] pos,
                                input logic [7:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {val, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(act, pos, val);
        pace_sender();
    endtask

    task automatic wait_for_drain();
        go_idle(1);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // grow and shrink phases so the list swings between empty and full
    task automatic random_requests(input int n);
        int         i;
        int         roll;
        int         fill_now;
        bit         grow;
        logic [2:0] act;
        logic [7:0] pos;
        logic [7:0] val;
        grow = 1'b1;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                grow = ~grow;
            fill_now = sb.fill;
            roll     = $urandom_range(0, 99);
            if (roll < 4)
                act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
            else if (roll < (grow ? 30 : 12))
                act = ACT_APPEND;
            else if (roll < (grow ? 58 : 20))
                act = ACT_INSERT;
            else if (roll < (grow ? 68 : 60))
                act = ACT_DELETE;
            else if (roll < (grow ? 84 : 80))
                act = ACT_GET;
            else
                act = ACT_LOCATE;
            case ($urandom_range(0, 9))
                0: pos = 8'($urandom_range(0, 255));
                1: pos = 8'd0;
                2: pos = 8'(fill_now + 1);
                default:
                begin
                    if (act == ACT_INSERT)
                        pos = 8'($urandom_range(1, fill_now + 1));
                    else
                        pos = 8'($urandom_range(1, (fill_now > 0) ? fill_now : 1));
                end
            endcase
            if (act == ACT_LOCATE && fill_now > 0 && $urandom_range(0, 2) != 0)
                val = sb.slots[$urandom_range(0, fill_now - 1)];
            else if ($urandom_range(0, 3) == 0)
                val = value_pool[$urandom_range(0, 3)];
            else
                val = 8'($urandom_range(0, 255));
            send_request(act, pos, val);
        end
    endtask

    // receiver: own stall pattern, plus long holds on request
    initial
    begin
        int   stall_left;
        int   phase_left;
        logic level;
        stall_left = 0;
        phase_left = 0;
        level      = 1'b1;
        m_tready   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            level      = 1'b1;
                            phase_left = $urandom_range(30, 120);
                        end
                        1:
                        begin
                            level      = 1'b0;
                            phase_left = $urandom_range(1, 8);
                        end
                        default:
                        begin
                            level      = 1'($urandom_range(0, 1));
                            phase_left = $urandom_range(1, 4);
                        end
                    endcase
                end
                phase_left--;
                m_tready <= level;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial
    begin
        while (cycle_count <= LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, bad positions
        send_request(ACT_GET,    8'd1,   8'h00);
        send_request(ACT_DELETE, 8'd1,   8'h00);
        send_request(ACT_LOCATE, 8'd0,   8'h00);
        send_request(ACT_INSERT, 8'd0,   8'h11);
        send_request(ACT_INSERT, 8'd2,   8'h22);
        // build FF 00 FF, check first match among duplicates
        send_request(ACT_INSERT, 8'd1,   8'h00);
        send_request(ACT_INSERT, 8'd2,   8'hFF);
        send_request(ACT_INSERT, 8'd1,   8'hFF);
        send_request(ACT_LOCATE, 8'd0,   8'hFF);
        send_request(ACT_GET,    8'd255, 8'h00);
        send_request(ACT_DELETE, 8'd4,   8'h00);
        send_request(ACT_UNUSED_FIRST, 8'h5A, 8'hA5);
        send_request(ACT_UNUSED_LAST,  8'hFF, 8'hFF);
        // fill to capacity, then push past it
        while (sb.fill < CAPACITY)
            send_request(ACT_APPEND, 8'd0, 8'(sb.fill * 37));
        send_request(ACT_APPEND, 8'd0,   8'h77);
        send_request(ACT_INSERT, 8'd1,   8'h77);
        send_request(ACT_GET,    8'(CAPACITY), 8'h00);
        send_request(ACT_DELETE, 8'(CAPACITY), 8'h00);

        random_requests(360);
        hold_request = 150;
        random_requests(40);
        wait_for_drain();
        random_requests(400);
        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("covered %0d requests and %0d results: %0d refused on a full list, %0d locate hits",
                 sb.n_requests, sb.n_results, sb.n_full_refusals, sb.n_locate_hits);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
